// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the filter.
// Each macro expands to one labeled concurrent assertion clocked by clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cvf assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define CVF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cvf assertion failed");

// Next-cycle implication that also holds through reset.
`define CVF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cvf assertion failed");

`endif

// ----- rtl/cvf_pkg.sv -----
// Package of the 3x3 convolution filter: types, constants and codes.
// Used by the filter top, its channel interfaces, line store, accumulator and divider; depends on nothing.
package cvf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int PIX_W         = 32;
  localparam int CH_W          = 8;
  localparam int IMG_W_W       = 11;
  localparam int IMG_H_W       = 13;
  localparam int ROW_W         = 12;
  localparam int ROW_LIMIT     = 4096;
  localparam int COEF_W        = 24;
  localparam int DIV_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int SUM_W         = 20;
  localparam int MAG_W         = 19;
  localparam int EXT_W         = 13;
  localparam int TAPS          = 9;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 3'd0,
    CFG_HEIGHT   = 3'd1,
    CFG_COEF_TOP = 3'd2,
    CFG_COEF_MID = 3'd3,
    CFG_COEF_BOT = 3'd4,
    CFG_DIVISOR  = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_MAC,
    ST_DIV,
    ST_PACK
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // Signed 8-bit coefficient at column col (0 left, 2 right) of a packed row.
  function automatic logic signed [CH_W-1:0] coef_at(input logic [COEF_W-1:0] row,
                                                     input logic [1:0] col);
    logic signed [CH_W-1:0] c;
    unique case (col)
      2'd0:    c = row[23:16];
      2'd1:    c = row[15:8];
      default: c = row[7:0];
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/cvf_in_if.sv -----
// Request channel of the filter: opcode and pixel with valid/ready.
// Depends on cvf_pkg for the field widths.
interface cvf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [cvf_pkg::PIX_W-1:0] pixel_in;
  modport source (output valid, opcode, pixel_in, input ready);
  modport sink   (input valid, opcode, pixel_in, output ready);
endinterface

// ----- rtl/cvf_out_if.sv -----
// Result channel of the filter: filtered pixel and frame end flag.
// Depends on cvf_pkg for the field widths.
interface cvf_out_if;
  logic                      valid;
  logic                      ready;
  logic [cvf_pkg::PIX_W-1:0] pixel_out;
  logic                      frame_end;
  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink   (input valid, pixel_out, frame_end, output ready);
endinterface

// ----- rtl/cvf_cfg_if.sv -----
// Register write channel of the filter: index and data with valid/ready.
// Depends on cvf_pkg for the field widths.
interface cvf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cvf_pkg::CFG_IDX_W-1:0]  index;
  logic [cvf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/conv3x3_rgb_filter.sv -----
// Channel  | Dir | Fields                      | Request accepted when
// in_ch    | in  | opcode, pixel_in            | valid && ready
// out_ch   | out | pixel_out, frame_end        | valid && ready
// cfg_ch   | in  | index, data                 | valid && ready (always ready)
// One request at a time: the block takes it, reads and updates the line store and,
// for a request that gives a result, runs the tap accumulator and the divider and
// then loads the result.
// The result register lets the next request in while a result waits.
// A full result register stalls the block before loading. Reset is synchronous,
// active low; the line stores are not cleared and need no clearing pass.
module conv3x3_rgb_filter #(
  parameter int MAX_WIDTH = cvf_pkg::DEF_MAX_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  cvf_in_if.sink   in_ch,
  cvf_out_if.source out_ch,
  cvf_cfg_if.sink  cfg_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_WIDTH + 3);
  localparam int EW = cvf_pkg::EXT_W;
  localparam int RW = cvf_pkg::ROW_W;

  cvf_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [cvf_pkg::IMG_W_W-1:0] image_width_r;
  logic [cvf_pkg::IMG_H_W-1:0] image_height_r;
  logic [cvf_pkg::COEF_W-1:0]  coef_r [3];
  logic [cvf_pkg::DIV_W-1:0]   divisor_r;

  // Position and window state.
  logic [CW-1:0]             in_col_r, out_col_r;
  logic [RW-1:0]             in_row_r, out_row_r;
  logic [PW-1:0]             pending_r;
  logic [cvf_pkg::PIX_W-1:0] win_r [cvf_pkg::TAPS];
  cvf_pkg::op_t              op_r;
  logic [cvf_pkg::PIX_W-1:0] pix_r;
  logic [CW-1:0]             addr_r, rd_addr;

  // Captured filter job.
  cvf_pkg::rgb_t             taps_r [cvf_pkg::TAPS];
  logic [7:0]                alpha_r;
  logic                      czero_r;
  logic                      fend_r;

  // Result register.
  logic                      out_valid_r;
  logic [cvf_pkg::PIX_W-1:0] out_pix_r;
  logic                      out_fe_r;

  logic [cvf_pkg::PIX_W-1:0] rd_upper, rd_lower;
  logic [EW-1:0]             w_eff, w_m1, h_eff, h_m1;
  logic                      wrap, go, emit, is_push, frame_end_now;
  logic [PW-1:0]             pend_inc;
  logic [cvf_pkg::PIX_W-1:0] win_sh [cvf_pkg::TAPS];
  logic [cvf_pkg::PIX_W-1:0] sel_w  [cvf_pkg::TAPS];
  logic [cvf_pkg::PIX_W-1:0] col_in [3];
  logic [1:0]                csel [3];
  logic [1:0]                rsel [3];
  cvf_pkg::rgb_t             taps_nxt [cvf_pkg::TAPS];
  logic [cvf_pkg::PIX_W-1:0] centre;
  logic                      mac_done, div_done, load_out;
  logic signed [cvf_pkg::SUM_W-1:0] sums [3];
  logic [cvf_pkg::CH_W-1:0]  quot [3];

  // Effective frame bounds.
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = EW'(1);
    end else if (EW'(image_width_r) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = EW'(1);
    end else if (image_height_r > EW'(cvf_pkg::ROW_LIMIT)) begin
      h_eff = EW'(cvf_pkg::ROW_LIMIT);
    end else begin
      h_eff = image_height_r;
    end
    w_m1 = w_eff - EW'(1);
    h_m1 = h_eff - EW'(1);
  end

  assign wrap          = EW'(out_col_r) >= w_m1;
  assign frame_end_now = wrap && (EW'(out_row_r) >= h_m1);
  assign is_push       = (op_r == cvf_pkg::OP_PUSH);
  assign pend_inc      = pending_r + PW'(1);
  assign go            = (14'(pend_inc) > (14'(w_eff) + 14'd1));
  assign emit          = is_push ? go : (pending_r != '0);

  // Line store address of the request.
  always_comb begin
    if (is_push) begin
      rd_addr = in_col_r;
    end else if (wrap) begin
      rd_addr = '0;
    end else begin
      rd_addr = CW'(out_col_r + CW'(1));
    end
  end

  cvf_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_store (
    .clk      (clk),
    .rd_en    (state_r == cvf_pkg::ST_READ),
    .rd_addr  (rd_addr),
    .wr_en    (state_r == cvf_pkg::ST_UPDATE && is_push),
    .wr_addr  (addr_r),
    .wr_upper (rd_lower),
    .wr_lower (pix_r),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower)
  );

  // Shifted window and the neighbor taps of the current output position.
  always_comb begin
    logic [23:0] prev;
    col_in[0] = rd_upper;
    col_in[1] = rd_lower;
    col_in[2] = is_push ? pix_r : rd_lower;
    for (int r = 0; r < 3; r++) begin
      win_sh[r*3]     = win_r[r*3 + 1];
      win_sh[r*3 + 1] = win_r[r*3 + 2];
      win_sh[r*3 + 2] = col_in[r];
    end
    for (int t = 0; t < cvf_pkg::TAPS; t++) begin
      sel_w[t] = wrap ? win_r[t] : win_sh[t];
    end
    csel[1] = wrap ? 2'd2 : 2'd1;
    csel[2] = 2'd2;
    csel[0] = (out_col_r == '0) ? csel[1] : csel[1] - 2'd1;
    rsel[0] = (out_row_r == '0) ? 2'd1 : 2'd0;
    rsel[1] = 2'd1;
    rsel[2] = (EW'(out_row_r) >= h_m1) ? 2'd1 : 2'd2;
    centre  = sel_w[3 + 32'(csel[1])];
    // A transparent neighbor repeats the previous one in its row.
    for (int i = 0; i < 3; i++) begin
      prev = '0;
      for (int j = 0; j < 3; j++) begin
        if (sel_w[32'(rsel[i]) * 3 + 32'(csel[j])] != '0) begin
          prev = sel_w[32'(rsel[i]) * 3 + 32'(csel[j])][23:0];
        end
        taps_nxt[i*3 + j] = prev;
      end
    end
  end

  // Configuration writes; indexes past the list are dropped.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= cvf_pkg::IMG_W_W'(640);
      image_height_r <= cvf_pkg::IMG_H_W'(480);
      coef_r[0]      <= '0;
      coef_r[1]      <= cvf_pkg::COEF_W'(256);
      coef_r[2]      <= '0;
      divisor_r      <= cvf_pkg::DIV_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cvf_pkg::cfg_idx_t'(cfg_ch.index))
        cvf_pkg::CFG_WIDTH:    image_width_r  <= cfg_ch.data[cvf_pkg::IMG_W_W-1:0];
        cvf_pkg::CFG_HEIGHT:   image_height_r <= cfg_ch.data[cvf_pkg::IMG_H_W-1:0];
        cvf_pkg::CFG_COEF_TOP: coef_r[0]      <= cfg_ch.data;
        cvf_pkg::CFG_COEF_MID: coef_r[1]      <= cfg_ch.data;
        cvf_pkg::CFG_COEF_BOT: coef_r[2]      <= cfg_ch.data;
        cvf_pkg::CFG_DIVISOR:  divisor_r      <= cfg_ch.data[cvf_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      cvf_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = cvf_pkg::ST_READ;
      cvf_pkg::ST_READ:   state_nxt = cvf_pkg::ST_UPDATE;
      cvf_pkg::ST_UPDATE: state_nxt = emit ? cvf_pkg::ST_MAC : cvf_pkg::ST_IDLE;
      cvf_pkg::ST_MAC:    if (mac_done) state_nxt = cvf_pkg::ST_DIV;
      cvf_pkg::ST_DIV:    if (div_done) state_nxt = cvf_pkg::ST_PACK;
      cvf_pkg::ST_PACK: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = cvf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cvf_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == cvf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture and job capture.
  always_ff @(posedge clk) begin
    if (state_r == cvf_pkg::ST_IDLE && in_ch.valid) begin
      op_r  <= cvf_pkg::op_t'(in_ch.opcode);
      pix_r <= in_ch.pixel_in;
    end
    if (state_r == cvf_pkg::ST_READ) begin
      addr_r <= rd_addr;
    end
    if (state_r == cvf_pkg::ST_UPDATE) begin
      taps_r  <= taps_nxt;
      alpha_r <= centre[31:24];
      czero_r <= (centre == '0);
      fend_r  <= frame_end_now;
    end
  end

  // Counters and window update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pending_r <= '0;
      for (int t = 0; t < cvf_pkg::TAPS; t++) win_r[t] <= '0;
    end else if (state_r == cvf_pkg::ST_UPDATE && (is_push || emit)) begin
      win_r <= win_sh;
      if (is_push) begin
        pending_r <= go ? pending_r : pend_inc;
        if (EW'(in_col_r) >= w_m1) begin
          in_col_r <= '0;
          in_row_r <= (EW'(in_row_r) >= h_m1) ? '0 : in_row_r + RW'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end else begin
        pending_r <= pending_r - PW'(1);
      end
      if (emit) begin
        if (wrap) begin
          out_col_r <= '0;
          out_row_r <= (EW'(out_row_r) >= h_m1) ? '0 : out_row_r + RW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  cvf_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == cvf_pkg::ST_UPDATE && emit),
    .taps      (taps_r),
    .coef_rows (coef_r),
    .done      (mac_done),
    .sums      (sums)
  );

  cvf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == cvf_pkg::ST_MAC && mac_done),
    .dividend (sums),
    .divisor  (divisor_r),
    .done     (div_done),
    .quot     (quot)
  );

  // Result register; transparent centre or black result gives zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (czero_r || (quot[0] == '0 && quot[1] == '0 && quot[2] == '0)) begin
        out_pix_r <= '0;
      end else begin
        out_pix_r <= {alpha_r, quot[0], quot[1], quot[2]};
      end
      out_fe_r <= fend_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.frame_end = out_fe_r;

endmodule

// ----- rtl/cvf_line_store.sv -----
// Two line stores of the filter, upper and lower, sharing one read and one write address.
// Synchronous read, registered while rd_en is high; depends on cvf_pkg.
module cvf_line_store #(
  parameter int DEPTH = cvf_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cvf_pkg::PIX_W-1:0] wr_upper,
  input  logic [cvf_pkg::PIX_W-1:0] wr_lower,
  output logic [cvf_pkg::PIX_W-1:0] rd_upper,
  output logic [cvf_pkg::PIX_W-1:0] rd_lower
);

  logic [cvf_pkg::PIX_W-1:0] upper_mem [DEPTH];
  logic [cvf_pkg::PIX_W-1:0] lower_mem [DEPTH];

  // Both stores are written together at one address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_upper;
      lower_mem[wr_addr] <= wr_lower;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper <= upper_mem[rd_addr];
      rd_lower <= lower_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/cvf_mac.sv -----
// Tap accumulator of the filter: one window tap per cycle for all three channels.
// Depends on cvf_pkg for the pixel and coefficient types.
module cvf_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  cvf_pkg::rgb_t                      taps [cvf_pkg::TAPS],
  input  logic [cvf_pkg::COEF_W-1:0]         coef_rows [3],
  output logic                               done,
  output logic signed [cvf_pkg::SUM_W-1:0]   sums [3]
);

  logic                             busy_r;
  logic [1:0]                       row_r, row_nxt;
  logic [1:0]                       col_r, col_nxt;
  logic                             done_r;
  logic signed [cvf_pkg::SUM_W-1:0] acc_r [3];
  logic [3:0]                       tap_idx;
  cvf_pkg::rgb_t                    tap;
  logic signed [cvf_pkg::CH_W-1:0]  kc;
  logic signed [cvf_pkg::CH_W+8:0]  prod [3];
  logic                             last;

  // Tap under work and its coefficient.
  always_comb begin
    tap_idx = {row_r, 1'b0} + {2'b00, row_r} + {2'b00, col_r};
    tap     = taps[tap_idx];
    kc      = cvf_pkg::coef_at(coef_rows[row_r], col_r);
    prod[0] = $signed({1'b0, tap.r}) * kc;
    prod[1] = $signed({1'b0, tap.g}) * kc;
    prod[2] = $signed({1'b0, tap.b}) * kc;
    last    = (row_r == 2'd2) && (col_r == 2'd2);
    if (col_r == 2'd2) begin
      col_nxt = 2'd0;
      row_nxt = row_r + 2'd1;
    end else begin
      col_nxt = col_r + 2'd1;
      row_nxt = row_r;
    end
  end

  // Sequencer over the nine taps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      row_r  <= 2'd0;
      col_r  <= 2'd0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        row_r  <= 2'd0;
        col_r  <= 2'd0;
      end else if (busy_r) begin
        busy_r <= !last;
        row_r  <= row_nxt;
        col_r  <= col_nxt;
      end
    end
  end

  // Channel accumulators.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (start) begin
        acc_r[k] <= '0;
      end else if (busy_r) begin
        acc_r[k] <= acc_r[k] + cvf_pkg::SUM_W'(prod[k]);
      end
    end
  end

  assign done = done_r;
  assign sums = acc_r;

endmodule

// ----- rtl/cvf_div.sv -----
// Three-lane restoring divider of the filter, one quotient bit per cycle.
// Gives each channel sum over the divisor, truncated and clamped to 0..255; uses cvf_pkg.
module cvf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [cvf_pkg::SUM_W-1:0] dividend [3],
  input  logic [cvf_pkg::DIV_W-1:0]        divisor,
  output logic                             done,
  output logic [cvf_pkg::CH_W-1:0]         quot [3]
);

  localparam int MW = cvf_pkg::MAG_W;
  localparam int DW = cvf_pkg::DIV_W;

  logic                 busy_r;
  logic                 done_r;
  logic [4:0]           cnt_r;
  logic [DW-1:0]        d_r;
  logic                 neg_r [3];
  logic [MW-1:0]        mag_r [3];
  logic [DW-1:0]        rem_r [3];
  logic [MW-1:0]        q_r   [3];
  logic [DW:0]          rem_t [3];
  logic                 fits  [3];
  logic                 last;

  assign last = (cnt_r == 5'(MW - 1));

  // One restoring step per lane.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_t[k] = {rem_r[k], mag_r[k][MW-1]};
      fits[k]  = rem_t[k] >= {1'b0, d_r};
    end
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        busy_r <= !last;
        cnt_r  <= cnt_r + 5'd1;
      end
    end
  end

  // Datapath. A sum at or below zero truncates to a quotient that clamps to 0.
  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= (divisor == '0) ? DW'(1) : divisor;
    end
    for (int k = 0; k < 3; k++) begin
      if (start) begin
        neg_r[k] <= dividend[k][cvf_pkg::SUM_W-1] || (dividend[k] == '0);
        mag_r[k] <= dividend[k][MW-1:0];
        rem_r[k] <= '0;
        q_r[k]   <= '0;
      end else if (busy_r) begin
        mag_r[k] <= {mag_r[k][MW-2:0], 1'b0};
        rem_r[k] <= fits[k] ? DW'(rem_t[k] - {1'b0, d_r}) : rem_t[k][DW-1:0];
        q_r[k]   <= {q_r[k][MW-2:0], fits[k]};
      end
    end
  end

  // Clamp to the channel range.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (neg_r[k]) begin
        quot[k] = '0;
      end else if (q_r[k] > MW'(cvf_pkg::CH_MAX)) begin
        quot[k] = cvf_pkg::CH_MAX;
      end else begin
        quot[k] = q_r[k][cvf_pkg::CH_W-1:0];
      end
    end
  end

  assign done = done_r;

endmodule

// ----- rtl/cvf_checker.sv -----
// Port checker of the filter, bound to the top level.
// Depends on assert_macros.svh and the channel interfaces of the top level.
`include "assert_macros.svh"

module cvf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_out,
  input logic        frame_end
);

  // A result waiting on the sink holds its value.
  `CVF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_end))

  // The block takes one request at a time.
  `CVF_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // Reset leaves no result pending.
  `CVF_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // A new result never appears in the cycle right after a request is taken.
  `CVF_ASSERT_NXT(a_no_early_result, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind conv3x3_rgb_filter cvf_checker u_cvf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_out (out_ch.pixel_out),
  .frame_end (out_ch.frame_end)
);
